### rtl/core/ptm_pkg.sv
// progress text matcher shared package
// widths, character codes and the command/status structs between controller and datapath
// no dependencies
package ptm_pkg;

	localparam int COUNT_BITS   = 20;
	localparam int PCT_BITS     = COUNT_BITS + 7;
	localparam int PUSH_BITS    = COUNT_BITS + 4;
	localparam int DIV_CNT_BITS = $clog2(PCT_BITS);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [6:0]            PCT_SCALE = 7'd100;
	localparam logic [3:0]            DEC_SCALE = 4'd10;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_O     = 8'h6F;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef struct packed {
		logic first_clear;
		logic first_push;
		logic second_clear;
		logic second_push;
		logic div_start;
		logic div_step;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic is_digit;
		logic is_space;
		logic is_o;
		logic is_f;
		logic part_ge_whole;
		logic div_last;
	} dp_stat_t;

endpackage

### rtl/core/ptm_datapath.sv
// progress text matcher datapath: byte classifier, number accumulators,
// restoring divider for the percentage and the result register
// depends on ptm_pkg
module ptm_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [7:0]                   text_byte,
	input  ptm_pkg::dp_cmd_t             cmd,
	output ptm_pkg::dp_stat_t            stat,
	output logic [ptm_pkg::COUNT_BITS-1:0] done_count,
	output logic [ptm_pkg::COUNT_BITS-1:0] total_count,
	output logic [ptm_pkg::PCT_BITS-1:0]   percent,
	output logic                         finished,
	output logic                         zero_total
);
	import ptm_pkg::*;

	logic [COUNT_BITS-1:0]   first_q;
	logic [COUNT_BITS-1:0]   second_q;
	logic [COUNT_BITS-1:0]   push_base;
	logic [PUSH_BITS-1:0]    push_val;
	logic [COUNT_BITS-1:0]   push_sat;
	logic [3:0]              digit_val;

	logic [COUNT_BITS-1:0]   divisor_q;
	logic [COUNT_BITS-1:0]   rem_q;
	logic [PCT_BITS-1:0]     quot_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic                    fin_q;
	logic                    zero_q;
	logic [COUNT_BITS:0]     trial;
	logic [COUNT_BITS:0]     diff;
	logic                    trial_ge;

	logic [COUNT_BITS-1:0]   done_count_q;
	logic [COUNT_BITS-1:0]   total_count_q;
	logic [PCT_BITS-1:0]     percent_q;
	logic                    finished_q;
	logic                    zero_total_q;

	// character classes
	always_comb begin
		stat.is_digit      = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
		stat.is_space      = (text_byte == CH_SPACE);
		stat.is_o          = (text_byte == CH_O);
		stat.is_f          = (text_byte == CH_F);
		stat.part_ge_whole = (first_q >= second_q);
		stat.div_last      = (cnt_q == '0);
	end

	// decimal accumulate with saturation
	assign digit_val = 4'(text_byte - CH_ZERO);
	always_comb begin
		if (cmd.first_clear || cmd.second_clear)
			push_base = '0;
		else if (cmd.first_push)
			push_base = first_q;
		else
			push_base = second_q;
	end
	assign push_val = PUSH_BITS'(push_base) * PUSH_BITS'(DEC_SCALE) + PUSH_BITS'(digit_val);
	assign push_sat = (push_val > PUSH_BITS'(COUNT_MAX)) ? COUNT_MAX : push_val[COUNT_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= '0;
			second_q <= '0;
		end else begin
			if (cmd.first_push)
				first_q <= push_sat;
			if (cmd.second_push)
				second_q <= push_sat;
		end
	end

	// restoring divider, one quotient bit per cycle
	assign trial    = {rem_q, quot_q[PCT_BITS-1]};
	assign diff     = trial - {1'b0, divisor_q};
	assign trial_ge = (trial >= {1'b0, divisor_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= DIV_CNT_BITS'(PCT_BITS - 1);
		end else if (cmd.div_step && (cnt_q != '0)) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			divisor_q <= second_q;
			rem_q     <= '0;
			quot_q    <= PCT_BITS'(first_q) * PCT_BITS'(PCT_SCALE);
			fin_q     <= (first_q >= second_q);
			zero_q    <= (second_q == '0);
		end else if (cmd.div_step) begin
			rem_q  <= trial_ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
			quot_q <= {quot_q[PCT_BITS-2:0], trial_ge};
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			done_count_q  <= first_q;
			total_count_q <= divisor_q;
			percent_q     <= zero_q ? '0 : quot_q;
			finished_q    <= fin_q;
			zero_total_q  <= zero_q;
		end
	end

	assign done_count  = done_count_q;
	assign total_count = total_count_q;
	assign percent     = percent_q;
	assign finished    = finished_q;
	assign zero_total  = zero_total_q;

endmodule

### rtl/core/ptm_ctrl.sv
// progress text matcher controller: pattern state machine, divide sequencing,
// input stall and result valid
// depends on ptm_pkg
module ptm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              text_valid,
	output logic              text_stall,
	output logic              result_valid,
	input  logic              result_stall,
	input  ptm_pkg::dp_stat_t stat,
	output ptm_pkg::dp_cmd_t  cmd
);
	import ptm_pkg::*;

	typedef enum logic [7:0] {
		PH_IDLE    = 8'b0000_0001,
		PH_LEAD    = 8'b0000_0010,
		PH_FIRST   = 8'b0000_0100,
		PH_O       = 8'b0000_1000,
		PH_F       = 8'b0001_0000,
		PH_GAP     = 8'b0010_0000,
		PH_SECOND0 = 8'b0100_0000,
		PH_SECOND  = 8'b1000_0000
	} phase_t;

	typedef enum logic [2:0] {
		SEQ_SCAN = 3'b001,
		SEQ_DIV  = 3'b010,
		SEQ_HOLD = 3'b100
	} seq_t;

	phase_t phase_q, phase_d;
	seq_t   seq_q, seq_d;
	logic   stopped_q, stopped_d;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign text_stall   = (seq_q != SEQ_SCAN);
	assign accept       = text_valid && !text_stall;
	assign out_free     = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;

	always_comb begin
		phase_d   = phase_q;
		seq_d     = seq_q;
		stopped_d = stopped_q;
		cmd       = '0;
		case (seq_q)
			SEQ_SCAN: begin
				if (accept && !stopped_q) begin
					phase_d = PH_IDLE;
					case (phase_q)
						PH_IDLE: begin
							if (stat.is_space)
								phase_d = PH_LEAD;
						end
						PH_LEAD: begin
							if (stat.is_digit) begin
								cmd.first_clear = 1'b1;
								cmd.first_push  = 1'b1;
								phase_d         = PH_FIRST;
							end
						end
						PH_FIRST: begin
							if (stat.is_digit) begin
								cmd.first_push = 1'b1;
								phase_d        = PH_FIRST;
							end else if (stat.is_space) begin
								phase_d = PH_O;
							end
						end
						PH_O: begin
							if (stat.is_o)
								phase_d = PH_F;
						end
						PH_F: begin
							if (stat.is_f)
								phase_d = PH_GAP;
						end
						PH_GAP: begin
							if (stat.is_space)
								phase_d = PH_SECOND0;
						end
						PH_SECOND0: begin
							if (stat.is_digit) begin
								cmd.second_clear = 1'b1;
								cmd.second_push  = 1'b1;
								phase_d          = PH_SECOND;
							end
						end
						PH_SECOND: begin
							if (stat.is_digit) begin
								cmd.second_push = 1'b1;
								phase_d         = PH_SECOND;
							end else if (stat.is_space) begin
								cmd.div_start = 1'b1;
								seq_d         = SEQ_DIV;
								if (stat.part_ge_whole)
									stopped_d = 1'b1;
							end
						end
						default: phase_d = PH_IDLE;
					endcase
				end
			end
			SEQ_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last)
					seq_d = SEQ_HOLD;
			end
			SEQ_HOLD: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					seq_d        = SEQ_SCAN;
				end
			end
			default: seq_d = SEQ_SCAN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			seq_q       <= SEQ_SCAN;
			stopped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			seq_q     <= seq_d;
			stopped_q <= stopped_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
		end
	end

	a_start_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> accept && !stopped_q)
		else $error("divide started without an accepted transaction");

	a_stopped_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("stopped flag cleared");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free)
		else $error("result overwritten before transaction");

	a_div_to_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == SEQ_DIV) && stat.div_last |=> (seq_q == SEQ_HOLD) && text_stall)
		else $error("divider end not followed by hold");

endmodule

### rtl/core/progress_text_matcher_unit.sv
// progress text matcher top level
// joins ptm_ctrl and ptm_datapath; depends on ptm_pkg
//
// Scans one text byte per transaction for " <digits> of <digits> " and, on each full
// match, returns both numbers, done*100/total and the finished / zero-total flags.
// While scanning, a byte is taken every cycle. The closing space of a match
// starts a restoring divider that produces one quotient bit per cycle, so the
// input is stalled through all of the division and then while the result moves
// into the output register (longer if that register still holds an untaken
// result). Numbers saturate at 2^20-1. Once a match reports finished, later
// bytes are still taken but dropped, until reset.
module progress_text_matcher_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           text_valid,
	output logic                           text_stall,
	input  logic [7:0]                     text_byte,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [ptm_pkg::COUNT_BITS-1:0] done_count,
	output logic [ptm_pkg::COUNT_BITS-1:0] total_count,
	output logic [ptm_pkg::PCT_BITS-1:0]   percent,
	output logic                           finished,
	output logic                           zero_total
);
	import ptm_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	ptm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_stall   (text_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	ptm_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_byte   (text_byte),
		.cmd         (cmd),
		.stat        (stat),
		.done_count  (done_count),
		.total_count (total_count),
		.percent     (percent),
		.finished    (finished),
		.zero_total  (zero_total)
	);

endmodule

### verif/ptm_progress_checker.sv
// ptm_progress_checker: watches the text and result channels of progress_text_matcher_unit,
// predicts each progress report from the accepted text bytes and compares it field by field
// depends on ptm_pkg for the count widths and character codes
module ptm_progress_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           text_valid,
	input  logic                           text_stall,
	input  logic [7:0]                     text_byte,
	input  logic                           result_valid,
	input  logic                           result_stall,
	input  logic [ptm_pkg::COUNT_BITS-1:0] done_count,
	input  logic [ptm_pkg::COUNT_BITS-1:0] total_count,
	input  logic [ptm_pkg::PCT_BITS-1:0]   percent,
	input  logic                           finished,
	input  logic                           zero_total,
	output int                             error_count,
	output int                             pending_count,
	output int                             report_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import ptm_pkg::*;

	localparam int          MAX_SHOWN     = 10;
	localparam logic [63:0] PERCENT_SCALE = 64'd100;
	localparam logic [63:0] DECIMAL_BASE  = 64'd10;

	typedef enum logic [7:0] {
		SCAN_IDLE       = 8'b0000_0001,
		SCAN_LEAD       = 8'b0000_0010,
		SCAN_DONE       = 8'b0000_0100,
		SCAN_O          = 8'b0000_1000,
		SCAN_F          = 8'b0001_0000,
		SCAN_GAP        = 8'b0010_0000,
		SCAN_TOTAL_LEAD = 8'b0100_0000,
		SCAN_TOTAL      = 8'b1000_0000
	} scan_phase_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] done_count;
		logic [COUNT_BITS-1:0] total_count;
		logic [PCT_BITS-1:0]   percent;
		logic                  finished;
		logic                  zero_total;
	} progress_report_t;

	progress_report_t      report_q[$];
	scan_phase_t           phase;
	logic [COUNT_BITS-1:0] done_acc;
	logic [COUNT_BITS-1:0] total_acc;
	logic                  halted;

	initial begin
		error_count   = 0;
		pending_count = 0;
		report_count  = 0;
	end

	function automatic logic is_numeral(input logic [7:0] ch);
		return ch >= CH_ZERO && ch <= CH_NINE;
	endfunction

	// decimal accumulate, saturating at the count maximum
	function automatic logic [COUNT_BITS-1:0] add_digit(input logic [COUNT_BITS-1:0] acc,
			input logic [7:0] ch);
		logic [63:0] grown;
		grown = 64'(acc) * DECIMAL_BASE + 64'(ch - CH_ZERO);
		return (grown > 64'(COUNT_MAX)) ? COUNT_MAX : grown[COUNT_BITS-1:0];
	endfunction

	task automatic scan_char(input logic [7:0] ch);
		progress_report_t rep;
		scan_phase_t      upcoming;
		logic [63:0]      scaled;
		upcoming = SCAN_IDLE;
		if (!halted) begin
			case (phase)
				SCAN_IDLE: if (ch == CH_SPACE) upcoming = SCAN_LEAD;
				SCAN_LEAD: if (is_numeral(ch)) begin
					done_acc = add_digit('0, ch);
					upcoming = SCAN_DONE;
				end
				SCAN_DONE: if (is_numeral(ch)) begin
					done_acc = add_digit(done_acc, ch);
					upcoming = SCAN_DONE;
				end else if (ch == CH_SPACE) begin
					upcoming = SCAN_O;
				end
				SCAN_O: if (ch == CH_O) upcoming = SCAN_F;
				SCAN_F: if (ch == CH_F) upcoming = SCAN_GAP;
				SCAN_GAP: if (ch == CH_SPACE) upcoming = SCAN_TOTAL_LEAD;
				SCAN_TOTAL_LEAD: if (is_numeral(ch)) begin
					total_acc = add_digit('0, ch);
					upcoming = SCAN_TOTAL;
				end
				default: if (is_numeral(ch)) begin
					total_acc = add_digit(total_acc, ch);
					upcoming = SCAN_TOTAL;
				end else if (ch == CH_SPACE) begin
					rep.done_count  = done_acc;
					rep.total_count = total_acc;
					rep.zero_total  = (total_acc == '0);
					rep.finished    = (done_acc >= total_acc);
					scaled = rep.zero_total ? 64'd0
						: (64'(done_acc) * PERCENT_SCALE) / 64'(total_acc);
					rep.percent = scaled[PCT_BITS-1:0];
					report_q = {report_q, rep};
					if (rep.finished) halted = 1'b1;
				end
			endcase
			phase = upcoming;
		end
	endtask

	task automatic check_field(input string label, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			error_count++;
			if (error_count <= MAX_SHOWN)
				$display("%0t mismatch on %s: expected %0d, got %0d", $time, label, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		progress_report_t want;
		if (!arst_n) begin
			phase     = SCAN_IDLE;
			done_acc  = '0;
			total_acc = '0;
			halted    = 1'b0;
			report_q.delete();
		end else begin
			if (text_valid && !text_stall)
				scan_char(text_byte);
			if (result_valid && !result_stall) begin
				report_count++;
				if (report_q.size() == 0) begin
					error_count++;
					if (error_count <= MAX_SHOWN)
						$display("%0t unexpected report: done %0d total %0d percent %0d fin %b zero %b",
							$time, done_count, total_count, percent, finished, zero_total);
				end else begin
					want = report_q.pop_front();
					check_field("done_count", want.done_count, done_count);
					check_field("total_count", want.total_count, total_count);
					check_field("percent", want.percent, percent);
					check_field("finished", want.finished, finished);
					check_field("zero_total", want.zero_total, zero_total);
				end
			end
		end
		pending_count = report_q.size();
	end

endmodule

### verif/tb_progress_text_matcher_unit.sv
// tb_progress_text_matcher_unit: feeds progress text into progress_text_matcher_unit
// (directed lines, random matches, cut-off matches and noise) with random idling on both sides;
// depends on ptm_pkg, the block and ptm_progress_checker, which predicts and compares
module tb_progress_text_matcher_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import ptm_pkg::*;

	localparam logic [7:0] LINE_END    = 8'h0A;
	localparam int         RANDOM_BYTES = 1750;
	localparam int         HOLD_AFTER   = 12;
	localparam int         HOLD_CYCLES  = 500;

	typedef enum int {CLOSE_ZERO_TOTAL, CLOSE_OVERFLOW, CLOSE_EVEN} closing_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  text_valid   = 1'b0;
	logic                  text_stall;
	logic [7:0]            text_byte    = 8'h00;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [COUNT_BITS-1:0] done_count;
	logic [COUNT_BITS-1:0] total_count;
	logic [PCT_BITS-1:0]   percent;
	logic                  finished;
	logic                  zero_total;

	int fault_total;
	int waiting_reports;
	int report_total;

	int       bytes_sent   = 0;
	int       match_count  = 0;
	int       broken_count = 0;
	int       noise_count  = 0;
	int       calm_left    = 0;
	bit       sender_calm  = 1'b0;
	closing_t closing;

	logic [7:0] line_q[$];

	always begin
		#1ns clk = 1'b1;
		#1ns clk = 1'b0;
	end

	progress_text_matcher_unit u_top (.*);

	ptm_progress_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_stall   (text_stall),
		.text_byte    (text_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.done_count   (done_count),
		.total_count  (total_count),
		.percent      (percent),
		.finished     (finished),
		.zero_total   (zero_total),
		.error_count  (fault_total),
		.pending_count(waiting_reports),
		.report_count (report_total)
	);

	// mostly short gaps, a few long ones
	function automatic int idle_len(input bit calm);
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_byte(input logic [7:0] ch);
		int gap;
		if (calm_left == 0) begin
			calm_left   = $urandom_range(40, 300);
			sender_calm = ($urandom_range(0, 3) == 0);
		end
		calm_left--;
		gap = idle_len(sender_calm);
		if (gap > 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		text_valid <= 1'b1;
		text_byte  <= ch;
		@(posedge clk);
		while (text_stall) @(posedge clk);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_line();
		foreach (line_q[i]) send_byte(line_q[i]);
		line_q.delete();
	endtask

	task automatic append_char(input logic [7:0] ch);
		line_q = {line_q, ch};
	endtask

	// long form: 8 to 10 digits, always past the count maximum
	task automatic add_number(input int unsigned v, input bit long_form);
		logic [7:0] digits[$];
		int         pad;
		if (long_form) begin
			append_char(CH_ZERO + 8'($urandom_range(1, 9)));
			repeat ($urandom_range(7, 9)) append_char(CH_ZERO + 8'($urandom_range(0, 9)));
		end else begin
			pad = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
			repeat (pad) append_char(CH_ZERO);
			do begin
				digits.push_front(CH_ZERO + 8'(v % 10));
				v = v / 10;
			end while (v != 0);
			line_q = {line_q, digits};
		end
	endtask

	task automatic add_match(input int unsigned part, input int unsigned whole,
			input bit part_long, input bit whole_long);
		append_char(CH_SPACE);
		add_number(part, part_long);
		append_char(CH_SPACE);
		append_char(CH_O);
		append_char(CH_F);
		append_char(CH_SPACE);
		add_number(whole, whole_long);
		append_char(CH_SPACE);
	endtask

	// part always below whole so the matcher keeps running
	task automatic add_random_match();
		int unsigned whole;
		int unsigned part;
		bit          whole_long;
		int          r;
		whole_long = 1'b0;
		r = $urandom_range(0, 99);
		if (r < 55) whole = $urandom_range(1, 999);
		else if (r < 80) whole = $urandom_range(1, COUNT_MAX);
		else if (r < 90) begin
			whole      = COUNT_MAX;
			whole_long = 1'b1;
		end else whole = COUNT_MAX;
		r = $urandom_range(0, 99);
		if (r < 10) part = 0;
		else if (r < 25) part = whole - 1;
		else part = $urandom_range(0, whole - 1);
		add_match(part, whole, 1'b0, whole_long);
	endtask

	task automatic add_noise();
		repeat ($urandom_range(1, 8)) append_char(8'($urandom_range(0, 255)));
		append_char(LINE_END);
	endtask

	initial begin : stimulus
		int          random_end;
		int          r;
		int          cut;
		int unsigned even;
		logic [7:0]  breaker;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// extreme bytes, a zero part, a doubled leading space that kills the match
		append_char(8'h00);
		append_char(8'hFF);
		add_match(0, 7, 1'b0, 1'b0);
		append_char(CH_SPACE);
		add_match(1, 3, 1'b0, 1'b0);
		add_match(2, 3, 1'b0, 1'b0);
		send_line();

		random_end = bytes_sent + RANDOM_BYTES;
		while (bytes_sent < random_end) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				add_random_match();
				match_count++;
			end else if (r < 85) begin
				add_random_match();
				cut    = $urandom_range(1, line_q.size() - 1);
				line_q = line_q[0:cut-1];
				do breaker = 8'($urandom_range(0, 255));
				while ((breaker >= CH_ZERO && breaker <= CH_NINE) || breaker == CH_SPACE);
				append_char(breaker);
				broken_count++;
			end else begin
				add_noise();
				noise_count++;
			end
			send_line();
		end

		// one finishing match, then text that must be ignored
		closing = closing_t'($urandom_range(0, 2));
		case (closing)
			CLOSE_ZERO_TOTAL: add_match($urandom_range(0, COUNT_MAX), 0, 1'b0, 1'b0);
			CLOSE_OVERFLOW: add_match(0, 1, 1'b1, 1'b0);
			default: begin
				even = $urandom_range(1, COUNT_MAX);
				add_match(even, even, 1'b0, 1'b0);
			end
		endcase
		add_random_match();
		add_noise();
		add_random_match();
		send_line();
		text_valid <= 1'b0;

		wait (waiting_reports == 0);
		repeat (100) @(posedge clk);
		$display("sent %0d text bytes: %0d random matches, %0d cut-off matches, %0d noise bursts",
			bytes_sent, match_count, broken_count, noise_count);
		$display("checked %0d reports; closing match kind %s", report_total, closing.name());
		if (fault_total == 0 && waiting_reports == 0) begin
			$display("tb_progress_text_matcher_unit passed");
		end else begin
			$display("tb_progress_text_matcher_unit failed");
		end
		$finish;
	end

	initial begin : receiver
		int hold;
		int taken;
		int quiet_left;
		bit quiet;
		hold       = 0;
		taken      = 0;
		quiet_left = 0;
		quiet      = 1'b0;
		forever begin
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(negedge clk);
				result_stall <= 1'b0;
			end
			@(posedge clk);
			while (!result_valid) @(posedge clk);
			@(negedge clk);
			taken++;
			if (quiet_left == 0) begin
				quiet_left = $urandom_range(5, 30);
				quiet      = ($urandom_range(0, 3) == 0);
			end
			quiet_left--;
			// one long hold so the block backs up into the text channel
			hold = (taken == HOLD_AFTER) ? HOLD_CYCLES : idle_len(quiet);
		end
	end

	initial begin : watchdog
		#2ms;
		$display("tb_progress_text_matcher_unit failed");
		$finish;
	end

endmodule

### progress_text_matcher_unit.f
rtl/core/ptm_pkg.sv
rtl/core/ptm_datapath.sv
rtl/core/ptm_ctrl.sv
rtl/core/progress_text_matcher_unit.sv
verif/ptm_progress_checker.sv
verif/tb_progress_text_matcher_unit.sv
